/* design/ievs_pkg.sv */
// Shared constants, request/result types and sequencer states for the indexed event list sorter.
// No dependencies.
package ievs_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int CMD_W       = 3;
    localparam int KEY_W       = 64;
    localparam int STATUS_W    = 2;

    localparam logic [CMD_W-1:0] CMD_ADD    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_GET    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_FIND   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SORT   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd5;

    localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BADPOS = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_NOSLOT = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]        cmd;
        logic signed [KEY_W-1:0] onset_key;
        logic [ADDR_W-1:0]       position;
        logic [ADDR_W-1:0]       slot;
    } ievs_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic [ADDR_W-1:0]       item_slot;
        logic signed [KEY_W-1:0] item_onset;
        logic [ADDR_W-1:0]       found_position;
        logic [CNT_W-1:0]        entry_count;
    } ievs_res_t;

    typedef struct packed {
        logic ready;
        logic done;
    } ievs_ctl_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_EXEC,
        S_GET_KEY,
        S_GET_WAIT,
        S_FD_RD,
        S_FD_CMP,
        S_RM_RD,
        S_RM_WR,
        S_SO_RD_MOV,
        S_SO_RD_KEY,
        S_SO_RD_PKEY,
        S_SO_CMP_PREV,
        S_SO_BS_RD,
        S_SO_BS_KEY,
        S_SO_BS_CMP,
        S_SO_SH_RD,
        S_SO_SH_WR,
        S_DONE
    } ievs_state_t;

endpackage

/* design/ievs_seq.sv */
// Command sequencer with the key and order memories (registered reads).
// Depends on ievs_pkg.
module ievs_seq
    import ievs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  ievs_req_t req,
    input  logic      res_ready,
    output ievs_ctl_t ctl,
    output ievs_res_t res
);

    logic signed [KEY_W-1:0] key_mem [TABLE_DEPTH];
    logic [ADDR_W-1:0]       ord_mem [TABLE_DEPTH];

    ievs_state_t state_reg, state_next;
    ievs_req_t   req_reg, req_next;

    logic [CNT_W-1:0] list_count_reg, list_count_next;
    logic [CNT_W-1:0] slots_used_reg, slots_used_next;
    logic [CNT_W-1:0] i_reg, i_next;
    logic [CNT_W-1:0] j_reg, j_next;
    logic [CNT_W-1:0] lo_reg, lo_next;
    logic [CNT_W-1:0] hi_reg, hi_next;
    logic [CNT_W-1:0] mid_reg, mid_next;
    logic [ADDR_W-1:0] moving_reg, moving_next;
    logic signed [KEY_W-1:0] sort_key_reg, sort_key_next;

    logic [STATUS_W-1:0]     res_status_reg, res_status_next;
    logic [ADDR_W-1:0]       res_slot_reg, res_slot_next;
    logic signed [KEY_W-1:0] res_onset_reg, res_onset_next;
    logic [ADDR_W-1:0]       res_pos_reg, res_pos_next;

    logic                    key_re, key_we;
    logic [ADDR_W-1:0]       key_raddr, key_waddr;
    logic signed [KEY_W-1:0] key_wdata, key_q;
    logic                    ord_re, ord_we;
    logic [ADDR_W-1:0]       ord_raddr, ord_waddr, ord_wdata, ord_q;

    logic             full, pos_bad, key_lt, i_last, short_list;
    logic [CNT_W:0]   mid_sum;
    logic [CNT_W-1:0] mid_w;
    logic [CNT_W-1:0] i_inc, j_inc;

    assign full = (slots_used_reg >= CNT_W'(TABLE_DEPTH))
               || (list_count_reg >= CNT_W'(TABLE_DEPTH));
    assign pos_bad    = CNT_W'(req_reg.position) >= list_count_reg;
    assign key_lt     = sort_key_reg < key_q;
    assign i_inc      = i_reg + CNT_W'(1);
    assign j_inc      = j_reg + CNT_W'(1);
    assign i_last     = i_inc >= list_count_reg;
    assign short_list = list_count_reg < CNT_W'(2);
    assign mid_sum    = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid_w      = mid_sum[CNT_W:1];

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                case (req_reg.cmd)
                    CMD_REMOVE: state_next = pos_bad ? S_DONE : S_RM_RD;
                    CMD_GET:    state_next = pos_bad ? S_DONE : S_GET_KEY;
                    CMD_FIND:   state_next = S_FD_RD;
                    CMD_SORT:   state_next = short_list ? S_DONE : S_SO_RD_MOV;
                    default:    state_next = S_DONE;
                endcase
            end
            S_GET_KEY:  state_next = S_GET_WAIT;
            S_GET_WAIT: state_next = S_DONE;
            S_FD_RD:    state_next = (j_reg < list_count_reg) ? S_FD_CMP : S_DONE;
            S_FD_CMP:   state_next = (ord_q == req_reg.slot) ? S_DONE : S_FD_RD;
            S_RM_RD:    state_next = (j_reg < list_count_reg) ? S_RM_WR : S_DONE;
            S_RM_WR:    state_next = S_RM_RD;
            S_SO_RD_MOV:  state_next = S_SO_RD_KEY;
            S_SO_RD_KEY:  state_next = S_SO_RD_PKEY;
            S_SO_RD_PKEY: state_next = S_SO_CMP_PREV;
            S_SO_CMP_PREV:
            begin
                if (key_lt)
                    state_next = S_SO_BS_RD;
                else
                    state_next = i_last ? S_DONE : S_SO_RD_MOV;
            end
            S_SO_BS_RD:  state_next = (lo_reg < hi_reg) ? S_SO_BS_KEY : S_SO_SH_RD;
            S_SO_BS_KEY: state_next = S_SO_BS_CMP;
            S_SO_BS_CMP: state_next = S_SO_BS_RD;
            S_SO_SH_RD:
            begin
                if (j_reg > lo_reg)
                    state_next = S_SO_SH_WR;
                else
                    state_next = i_last ? S_DONE : S_SO_RD_MOV;
            end
            S_SO_SH_WR: state_next = S_SO_SH_RD;
            S_DONE:
            begin
                if (res_ready)
                    state_next = start ? S_EXEC : S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        req_next        = req_reg;
        list_count_next = list_count_reg;
        slots_used_next = slots_used_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        moving_next     = moving_reg;
        sort_key_next   = sort_key_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_onset_next  = res_onset_reg;
        res_pos_next    = res_pos_reg;
        key_re    = 1'b0;
        key_raddr = '0;
        key_we    = 1'b0;
        key_waddr = '0;
        key_wdata = '0;
        ord_re    = 1'b0;
        ord_raddr = '0;
        ord_we    = 1'b0;
        ord_waddr = '0;
        ord_wdata = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                    req_next = req;
            end
            S_EXEC:
            begin
                res_status_next = STATUS_OK;
                res_slot_next   = '0;
                res_onset_next  = '0;
                res_pos_next    = '0;
                case (req_reg.cmd)
                    CMD_ADD:
                    begin
                        if (full)
                            res_status_next = STATUS_FULL;
                        else
                        begin
                            key_we          = 1'b1;
                            key_waddr       = slots_used_reg[ADDR_W-1:0];
                            key_wdata       = req_reg.onset_key;
                            ord_we          = 1'b1;
                            ord_waddr       = list_count_reg[ADDR_W-1:0];
                            ord_wdata       = slots_used_reg[ADDR_W-1:0];
                            res_slot_next   = slots_used_reg[ADDR_W-1:0];
                            list_count_next = list_count_reg + CNT_W'(1);
                            slots_used_next = slots_used_reg + CNT_W'(1);
                        end
                    end
                    CMD_REMOVE:
                    begin
                        if (pos_bad)
                            res_status_next = STATUS_BADPOS;
                        else
                        begin
                            list_count_next = list_count_reg - CNT_W'(1);
                            j_next          = CNT_W'(req_reg.position);
                        end
                    end
                    CMD_GET:
                    begin
                        if (pos_bad)
                            res_status_next = STATUS_BADPOS;
                        else
                        begin
                            ord_re    = 1'b1;
                            ord_raddr = req_reg.position;
                        end
                    end
                    CMD_FIND:
                    begin
                        res_status_next = STATUS_NOSLOT;
                        j_next          = '0;
                    end
                    CMD_SORT:
                    begin
                        i_next = CNT_W'(1);
                    end
                    CMD_CLEAR:
                    begin
                        list_count_next = '0;
                        slots_used_next = '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_GET_KEY:
            begin
                key_re        = 1'b1;
                key_raddr     = ord_q;
                res_slot_next = ord_q;
            end
            S_GET_WAIT:
            begin
                res_onset_next = key_q;
            end
            S_FD_RD:
            begin
                if (j_reg < list_count_reg)
                begin
                    ord_re    = 1'b1;
                    ord_raddr = j_reg[ADDR_W-1:0];
                end
            end
            S_FD_CMP:
            begin
                if (ord_q == req_reg.slot)
                begin
                    res_status_next = STATUS_OK;
                    res_pos_next    = j_reg[ADDR_W-1:0];
                end
                else
                    j_next = j_inc;
            end
            S_RM_RD:
            begin
                if (j_reg < list_count_reg)
                begin
                    ord_re    = 1'b1;
                    ord_raddr = j_inc[ADDR_W-1:0];
                end
            end
            S_RM_WR:
            begin
                ord_we    = 1'b1;
                ord_waddr = j_reg[ADDR_W-1:0];
                ord_wdata = ord_q;
                j_next    = j_inc;
            end
            S_SO_RD_MOV:
            begin
                ord_re    = 1'b1;
                ord_raddr = i_reg[ADDR_W-1:0];
            end
            S_SO_RD_KEY:
            begin
                moving_next = ord_q;
                key_re      = 1'b1;
                key_raddr   = ord_q;
                ord_re      = 1'b1;
                ord_raddr   = i_reg[ADDR_W-1:0] - ADDR_W'(1);
            end
            S_SO_RD_PKEY:
            begin
                sort_key_next = key_q;
                key_re        = 1'b1;
                key_raddr     = ord_q;
            end
            S_SO_CMP_PREV:
            begin
                if (key_lt)
                begin
                    lo_next = '0;
                    hi_next = i_reg;
                end
                else
                    i_next = i_inc;
            end
            S_SO_BS_RD:
            begin
                if (lo_reg < hi_reg)
                begin
                    mid_next  = mid_w;
                    ord_re    = 1'b1;
                    ord_raddr = mid_w[ADDR_W-1:0];
                end
                else
                    j_next = i_reg;
            end
            S_SO_BS_KEY:
            begin
                key_re    = 1'b1;
                key_raddr = ord_q;
            end
            S_SO_BS_CMP:
            begin
                if (key_lt)
                    hi_next = mid_reg;
                else
                    lo_next = mid_reg + CNT_W'(1);
            end
            S_SO_SH_RD:
            begin
                if (j_reg > lo_reg)
                begin
                    ord_re    = 1'b1;
                    ord_raddr = j_reg[ADDR_W-1:0] - ADDR_W'(1);
                end
                else
                begin
                    ord_we    = 1'b1;
                    ord_waddr = lo_reg[ADDR_W-1:0];
                    ord_wdata = moving_reg;
                    i_next    = i_inc;
                end
            end
            S_SO_SH_WR:
            begin
                ord_we    = 1'b1;
                ord_waddr = j_reg[ADDR_W-1:0];
                ord_wdata = ord_q;
                j_next    = j_reg - CNT_W'(1);
            end
            S_DONE:
            begin
                if (res_ready && start)
                    req_next = req;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            list_count_reg <= '0;
            slots_used_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            list_count_reg <= list_count_next;
            slots_used_reg <= slots_used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        i_reg          <= i_next;
        j_reg          <= j_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        mid_reg        <= mid_next;
        moving_reg     <= moving_next;
        sort_key_reg   <= sort_key_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_onset_reg  <= res_onset_next;
        res_pos_reg    <= res_pos_next;
    end

    always_ff @(posedge clk)
    begin
        if (key_we)
            key_mem[key_waddr] <= key_wdata;
        if (key_re)
            key_q <= key_mem[key_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (ord_we)
            ord_mem[ord_waddr] <= ord_wdata;
        if (ord_re)
            ord_q <= ord_mem[ord_raddr];
    end

    assign ctl.ready = (state_reg == S_IDLE) || ((state_reg == S_DONE) && res_ready);
    assign ctl.done  = (state_reg == S_DONE);

    assign res.status         = res_status_reg;
    assign res.item_slot      = res_slot_reg;
    assign res.item_onset     = res_onset_reg;
    assign res.found_position = res_pos_reg;
    assign res.entry_count    = list_count_reg;

`ifndef ASSERT_OFF
    a_count_le_used: assert property (@(posedge clk) disable iff (!rst_n)
        list_count_reg <= slots_used_reg)
        else $error("list count exceeds used slots");

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        slots_used_reg <= CNT_W'(TABLE_DEPTH))
        else $error("used slots beyond table depth");

    a_ord_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(ord_re && ord_we && (ord_raddr == ord_waddr)))
        else $error("order memory read and write hit the same entry");

    a_bs_window: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SO_BS_RD || state_reg == S_SO_BS_KEY || state_reg == S_SO_BS_CMP)
        |-> (lo_reg <= hi_reg) && (hi_reg <= i_reg))
        else $error("binary search window out of order");
`endif

endmodule

/* design/indexed_event_list_sorter_core.sv */
// Top level: request handshake, result register, and the command sequencer.
// Depends on ievs_pkg and ievs_seq.

// One request at a time. Get reads the order list, then the key table. Find
// scans the order list from position 0 until the slot matches; remove shifts
// every later entry down one position. Sort is an insertion sort: each entry
// that is smaller than its predecessor is placed by a binary search over the
// sorted entries before it, and the entries from there up are shifted up.
// The order memory has a single read port and a registered read. A new
// request is taken in the same cycle that the previous result moves into the
// output register.
module indexed_event_list_sorter_core
    import ievs_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [CMD_W-1:0]           cmd,
    input  logic signed [KEY_W-1:0]    onset_key,
    input  logic [ADDR_W-1:0]          position,
    input  logic [ADDR_W-1:0]          slot,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [STATUS_W-1:0]        status,
    output logic [ADDR_W-1:0]          item_slot,
    output logic signed [KEY_W-1:0]    item_onset,
    output logic [ADDR_W-1:0]          found_position,
    output logic [CNT_W-1:0]           entry_count
);

    ievs_req_t req;
    ievs_res_t seq_res;
    ievs_ctl_t seq_ctl;
    ievs_res_t out_res_reg;
    logic      out_valid_reg;
    logic      res_ready;
    logic      start;

    assign req.cmd       = cmd;
    assign req.onset_key = onset_key;
    assign req.position  = position;
    assign req.slot      = slot;

    assign res_ready = !out_valid_reg || !out_stall;
    assign in_stall  = !seq_ctl.ready;
    assign start     = in_valid && seq_ctl.ready;

    ievs_seq u_seq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .req       (req),
        .res_ready (res_ready),
        .ctl       (seq_ctl),
        .res       (seq_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (seq_ctl.done && res_ready)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (seq_ctl.done && res_ready)
            out_res_reg <= seq_res;
    end

    assign out_valid      = out_valid_reg;
    assign status         = out_res_reg.status;
    assign item_slot      = out_res_reg.item_slot;
    assign item_onset     = out_res_reg.item_onset;
    assign found_position = out_res_reg.found_position;
    assign entry_count    = out_res_reg.entry_count;

endmodule

/* tb/tb_indexed_event_list_sorter_core.sv */
// Self-checking testbench for indexed_event_list_sorter_core: random and directed requests,
// checked against a scoreboard that tracks the key table and order list.
// Depends on ievs_pkg and the sorter core RTL.
module tb_indexed_event_list_sorter_core
    import ievs_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CMD_W-1:0]        CMD_SPARE_LO = 3'd6;
    localparam logic [CMD_W-1:0]        CMD_SPARE_HI = 3'd7;
    localparam logic signed [KEY_W-1:0] ONSET_MAX    = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [KEY_W-1:0] ONSET_MIN    = 64'sh8000_0000_0000_0000;
    localparam int                      QUIET_LIMIT  = 4_000_000;
    localparam int                      LONG_HOLD    = 400;

    logic                    clk            = 1'b0;
    logic                    rst_n          = 1'b0;
    logic                    in_valid       = 1'b0;
    logic                    in_stall;
    logic [CMD_W-1:0]        cmd            = '0;
    logic signed [KEY_W-1:0] onset_key      = '0;
    logic [ADDR_W-1:0]       position       = '0;
    logic [ADDR_W-1:0]       slot           = '0;
    logic                    out_valid;
    logic                    out_stall      = 1'b0;
    logic [STATUS_W-1:0]     status;
    logic [ADDR_W-1:0]       item_slot;
    logic signed [KEY_W-1:0] item_onset;
    logic [ADDR_W-1:0]       found_position;
    logic [CNT_W-1:0]        entry_count;

    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    logic long_hold     = 1'b0;
    int   hold_cnt      = 0;
    int   quiet_cycles  = 0;

    class event_list_tracker;
        logic signed [KEY_W-1:0] onset_by_slot [TABLE_DEPTH];
        logic [ADDR_W-1:0]       slot_by_pos [TABLE_DEPTH];
        int                      listed;
        int                      slots_taken;
        int                      failures;
        ievs_res_t               awaited_results [$];

        function new();
            listed      = 0;
            slots_taken = 0;
            failures    = 0;
        endfunction

        function void note_request(ievs_req_t rq);
            ievs_res_t         rs;
            int                i;
            int                j;
            logic              stop;
            logic [ADDR_W-1:0] moving;
            rs = '0;
            case (rq.cmd)
                CMD_ADD:
                begin
                    if (slots_taken >= TABLE_DEPTH || listed >= TABLE_DEPTH)
                    begin
                        rs.status = STATUS_FULL;
                    end
                    else
                    begin
                        onset_by_slot[slots_taken] = rq.onset_key;
                        slot_by_pos[listed]        = ADDR_W'(slots_taken);
                        rs.item_slot               = ADDR_W'(slots_taken);
                        listed++;
                        slots_taken++;
                    end
                end
                CMD_REMOVE:
                begin
                    if (rq.position >= listed)
                    begin
                        rs.status = STATUS_BADPOS;
                    end
                    else
                    begin
                        listed--;
                        for (i = int'(rq.position); i < listed; i++)
                        begin
                            slot_by_pos[i] = slot_by_pos[i + 1];
                        end
                    end
                end
                CMD_GET:
                begin
                    if (rq.position >= listed)
                    begin
                        rs.status = STATUS_BADPOS;
                    end
                    else
                    begin
                        rs.item_slot  = slot_by_pos[rq.position];
                        rs.item_onset = onset_by_slot[slot_by_pos[rq.position]];
                    end
                end
                CMD_FIND:
                begin
                    rs.status = STATUS_NOSLOT;
                    for (i = 0; i < listed && rs.status != STATUS_OK; i++)
                    begin
                        if (slot_by_pos[i] == rq.slot)
                        begin
                            rs.status         = STATUS_OK;
                            rs.found_position = ADDR_W'(i);
                        end
                    end
                end
                CMD_SORT:
                begin
                    // stable insertion: equal keys keep their order
                    for (i = 1; i < listed; i++)
                    begin
                        moving = slot_by_pos[i];
                        j      = i;
                        stop   = 1'b0;
                        while (j > 0 && !stop)
                        begin
                            if (onset_by_slot[moving] < onset_by_slot[slot_by_pos[j - 1]])
                            begin
                                slot_by_pos[j] = slot_by_pos[j - 1];
                                j--;
                            end
                            else
                            begin
                                stop = 1'b1;
                            end
                        end
                        slot_by_pos[j] = moving;
                    end
                end
                CMD_CLEAR:
                begin
                    listed      = 0;
                    slots_taken = 0;
                end
                default:
                begin
                end
            endcase
            rs.entry_count = CNT_W'(listed);
            awaited_results.push_back(rs);
        endfunction

        function void compare_field(string name, logic [KEY_W-1:0] want,
                                    logic [KEY_W-1:0] got);
            if (got !== want)
            begin
                $error("%s expected 0x%0h got 0x%0h", name, want, got);
                failures++;
            end
        endfunction

        function void check_result(ievs_res_t got);
            ievs_res_t want;
            if (awaited_results.size() == 0)
            begin
                $error("result with no request outstanding");
                failures++;
                return;
            end
            want = awaited_results.pop_front();
            compare_field("status", KEY_W'(want.status), KEY_W'(got.status));
            compare_field("item_slot", KEY_W'(want.item_slot), KEY_W'(got.item_slot));
            compare_field("item_onset", want.item_onset, got.item_onset);
            compare_field("found_position", KEY_W'(want.found_position),
                          KEY_W'(got.found_position));
            compare_field("entry_count", KEY_W'(want.entry_count), KEY_W'(got.entry_count));
        endfunction
    endclass

    event_list_tracker sb;

    indexed_event_list_sorter_core uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .cmd            (cmd),
        .onset_key      (onset_key),
        .position       (position),
        .slot           (slot),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .item_slot      (item_slot),
        .item_onset     (item_onset),
        .found_position (found_position),
        .entry_count    (entry_count)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        if (long_hold)
        begin
            long_hold = 1'b0;
            hold_cnt  = LONG_HOLD;
        end
        if (hold_cnt > 0)
        begin
            hold_cnt--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        ievs_res_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.status         = status;
            got.item_slot      = item_slot;
            got.item_onset     = item_onset;
            got.found_position = found_position;
            got.entry_count    = entry_count;
            sb.check_result(got);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb_indexed_event_list_sorter_core NOT OK");
            $finish;
        end
    end

    function automatic logic signed [KEY_W-1:0] pick_onset();
        logic signed [KEY_W-1:0] k;
        case ($urandom_range(9))
            0: k = ONSET_MIN;
            1: k = ONSET_MAX;
            2, 3:
            begin
                k = KEY_W'($urandom_range(6));
                k = k - KEY_W'(3);
            end
            default: k = {$urandom(), $urandom()};
        endcase
        return k;
    endfunction

    task automatic issue(input logic [CMD_W-1:0] c, input logic signed [KEY_W-1:0] k,
                         input logic [ADDR_W-1:0] p, input logic [ADDR_W-1:0] s);
        ievs_req_t rq;
        rq.cmd       = c;
        rq.onset_key = k;
        rq.position  = p;
        rq.slot      = s;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        cmd       <= c;
        onset_key <= k;
        position  <= p;
        slot      <= s;
        do @(posedge clk); while (in_stall);
        sb.note_request(rq);
    endtask

    task automatic wait_for_results;
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.awaited_results.size() != 0) @(posedge clk);
    endtask

    function automatic logic [ADDR_W-1:0] any_index();
        return ADDR_W'($urandom_range(TABLE_DEPTH - 1));
    endfunction

    task automatic random_request;
        int                roll;
        logic [CMD_W-1:0]  c;
        logic [ADDR_W-1:0] p;
        logic [ADDR_W-1:0] s;
        roll = $urandom_range(99);
        if (sb.listed > 40)  c = CMD_CLEAR;
        else if (roll < 34)  c = CMD_ADD;
        else if (roll < 50)  c = CMD_GET;
        else if (roll < 62)  c = CMD_FIND;
        else if (roll < 74)  c = CMD_REMOVE;
        else if (roll < 84)  c = CMD_SORT;
        else if (roll < 88)  c = CMD_CLEAR;
        else if (roll < 91)  c = ($urandom_range(1) != 0) ? CMD_SPARE_HI : CMD_SPARE_LO;
        else                 c = CMD_W'($urandom_range((1 << CMD_W) - 1));
        if (sb.listed > 0 && $urandom_range(9) < 8)
            p = ADDR_W'($urandom_range(sb.listed - 1));
        else
            p = any_index();
        if (sb.slots_taken > 0 && $urandom_range(9) < 8)
            s = ADDR_W'($urandom_range(sb.slots_taken - 1));
        else
            s = any_index();
        issue(c, pick_onset(), p, s);
    endtask

    // mostly ascending keys keep the full-table sort short
    task automatic fill_storage;
        logic signed [KEY_W-1:0] k;
        int                      i;
        issue(CMD_CLEAR, pick_onset(), any_index(), any_index());
        k = -64'sd1000000000;
        for (i = 0; i < TABLE_DEPTH; i++)
        begin
            k = k + KEY_W'($urandom_range(1, 1000));
            issue(CMD_ADD, ($urandom_range(199) == 0) ? pick_onset() : k,
                  any_index(), any_index());
        end
        issue(CMD_ADD, pick_onset(), any_index(), any_index());
        issue(CMD_GET, pick_onset(), ADDR_W'(TABLE_DEPTH - 1), any_index());
        issue(CMD_FIND, pick_onset(), any_index(), ADDR_W'(TABLE_DEPTH - 1));
        issue(CMD_SORT, pick_onset(), any_index(), any_index());
        issue(CMD_GET, pick_onset(), ADDR_W'(TABLE_DEPTH - 1), any_index());
        issue(CMD_GET, pick_onset(), '0, any_index());
        issue(CMD_FIND, pick_onset(), any_index(), any_index());
        issue(CMD_REMOVE, pick_onset(), '0, any_index());
        issue(CMD_ADD, pick_onset(), any_index(), any_index());
        issue(CMD_REMOVE, pick_onset(), ADDR_W'(TABLE_DEPTH - 2), any_index());
        issue(CMD_GET, pick_onset(), ADDR_W'(TABLE_DEPTH - 2), any_index());
        issue(CMD_FIND, pick_onset(), any_index(), any_index());
        issue(CMD_CLEAR, pick_onset(), any_index(), any_index());
        issue(CMD_ADD, pick_onset(), any_index(), any_index());
    endtask

    initial
    begin
        sb = new();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty list, short list, extremes, duplicate keys, unused commands
        issue(CMD_GET, ONSET_MAX, '0, '0);
        issue(CMD_REMOVE, ONSET_MIN, ADDR_W'(TABLE_DEPTH - 1), '0);
        issue(CMD_FIND, '0, '0, '0);
        issue(CMD_SORT, '0, '0, '0);
        issue(CMD_ADD, ONSET_MAX, '0, '0);
        issue(CMD_SORT, '0, '0, '0);
        issue(CMD_ADD, ONSET_MIN, '0, '0);
        issue(CMD_ADD, '0, '0, '0);
        issue(CMD_ADD, -64'sd1, '0, '0);
        issue(CMD_ADD, 64'sd5, '0, '0);
        issue(CMD_ADD, -64'sd1, '0, '0);
        issue(CMD_ADD, ONSET_MIN, '0, '0);
        issue(CMD_GET, '0, 10'd1, '0);
        issue(CMD_FIND, '0, '0, 10'd3);
        issue(CMD_SORT, '0, '0, '0);
        issue(CMD_GET, '0, '0, '0);
        issue(CMD_GET, '0, 10'd6, '0);
        issue(CMD_FIND, '0, '0, 10'd5);
        issue(CMD_REMOVE, '0, 10'd3, '0);
        issue(CMD_GET, '0, 10'd6, '0);
        issue(CMD_FIND, '0, '0, ADDR_W'(TABLE_DEPTH - 1));
        issue(CMD_SPARE_LO, ONSET_MAX, ADDR_W'(TABLE_DEPTH - 1), ADDR_W'(TABLE_DEPTH - 1));
        issue(CMD_SPARE_HI, ONSET_MIN, '0, '0);
        issue(CMD_REMOVE, '0, '0, '0);
        issue(CMD_CLEAR, '0, '0, '0);
        issue(CMD_GET, '0, '0, '0);
        wait_for_results();

        send_idle_pct = 12;
        recv_idle_pct = 50;
        long_hold     = 1'b1;
        repeat (80) random_request();
        wait_for_results();

        send_idle_pct = 50;
        recv_idle_pct = 12;
        repeat (80) random_request();
        wait_for_results();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        fill_storage();
        repeat (70) random_request();
        wait_for_results();
        repeat (24) @(posedge clk);

        if (sb.failures == 0 && sb.awaited_results.size() == 0)
        begin
            $display("tb_indexed_event_list_sorter_core OK");
        end
        else
        begin
            $display("tb_indexed_event_list_sorter_core NOT OK");
        end
        $finish;
    end

endmodule
